// ----- sv/ccs_pkg.sv -----
package ccs_pkg;

  // history and heap sizing
  localparam int HIST_DEPTH = 1024;
  localparam int SLOT_W     = $clog2(HIST_DEPTH);
  localparam int FILL_W     = SLOT_W + 1;
  localparam int ERR_W      = 32;
  localparam int CNT_W      = 10;

  // a push is dropped once the heap holds this many entries
  localparam logic [FILL_W-1:0] HEAP_LIMIT = FILL_W'(HIST_DEPTH - 1);

  // result status codes
  localparam logic [1:0] STAT_NEXT  = 2'd0;
  localparam logic [1:0] STAT_DONE  = 2'd1;
  localparam logic [1:0] STAT_UNEXP = 2'd2;

  // input commands
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_RESULT = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN  = 2'd0;
  localparam logic [1:0] CFG_MAX  = 2'd1;
  localparam logic [1:0] CFG_MODE = 2'd2;

  // one interval with the counts and errors of both ends cached
  typedef struct packed {
    logic [SLOT_W-1:0] lslot;
    logic [SLOT_W-1:0] rslot;
    logic [CNT_W-1:0]  lcnt;
    logic [CNT_W-1:0]  rcnt;
    logic [ERR_W-1:0]  lerr;
    logic [ERR_W-1:0]  rerr;
  } ccs_entry_t;

  localparam int ENTRY_W = $bits(ccs_entry_t);

  // cross-multiplied ratio compare: p0*p1 > q0*q1
  typedef struct packed {
    logic [ERR_W-1:0] p0;
    logic [ERR_W-1:0] p1;
    logic [ERR_W-1:0] q0;
    logic [ERR_W-1:0] q1;
  } ccs_cmp_req_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    ccs_entry_t entry;
  } ccs_heap_req_t;

  typedef struct packed {
    logic       done;
    logic       popped;
    ccs_entry_t top;
  } ccs_heap_rsp_t;

endpackage

// ----- sv/ccs_ram.sv -----
module ccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/ccs_ratio_cmp.sv -----
module ccs_ratio_cmp (
  input  logic                 clk,
  input  ccs_pkg::ccs_cmp_req_t req,
  output logic                 gt
);

  logic [2*ccs_pkg::ERR_W-1:0] pa_r;
  logic [2*ccs_pkg::ERR_W-1:0] pb_r;

  // products registered, compare in the following cycle
  always_ff @(posedge clk) begin
    pa_r <= req.p0 * req.p1;
    pb_r <= req.q0 * req.q1;
  end

  assign gt = pa_r > pb_r;

endmodule

// ----- sv/ccs_heap.sv -----
module ccs_heap (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ccs_pkg::ccs_heap_req_t req,
  output ccs_pkg::ccs_heap_rsp_t rsp
);

  typedef enum logic [3:0] {
    H_IDLE, H_UP, H_UP_RD, H_UP_CMP, H_POP_RD1, H_POP_RD2,
    H_DN, H_DN_RD1, H_DN_RD2, H_DN_CMPC, H_DN_CMPX
  } hstate_t;

  hstate_t                       st_r;
  logic [ccs_pkg::FILL_W-1:0]    fill_r;
  logic [ccs_pkg::SLOT_W-1:0]    pos_r;
  ccs_pkg::ccs_entry_t           x_r;
  ccs_pkg::ccs_entry_t           c_r;
  ccs_pkg::ccs_entry_t           c1_r;
  ccs_pkg::ccs_entry_t           top_r;
  logic                          sel_r;
  logic                          done_r;
  logic                          popped_r;

  logic                          done_nxt;
  logic                          we;
  logic [ccs_pkg::SLOT_W-1:0]    waddr;
  ccs_pkg::ccs_entry_t           wdata;
  logic [ccs_pkg::SLOT_W-1:0]    raddr;
  logic [ccs_pkg::ENTRY_W-1:0]   rword;
  ccs_pkg::ccs_entry_t           rdata;
  ccs_pkg::ccs_entry_t           cmp_a;
  ccs_pkg::ccs_entry_t           cmp_b;
  ccs_pkg::ccs_cmp_req_t         cmp_req;
  logic                          gt;
  logic [ccs_pkg::FILL_W-1:0]    cidx;
  logic [ccs_pkg::FILL_W-1:0]    c1idx;

  assign rdata = ccs_pkg::ccs_entry_t'(rword);
  assign cidx  = {pos_r, 1'b0};
  assign c1idx = cidx + ccs_pkg::FILL_W'(1);

  ccs_ram #(
    .WIDTH (ccs_pkg::ENTRY_W),
    .DEPTH (ccs_pkg::HIST_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rword)
  );

  // better(a, b): a.lerr * b.rerr > b.lerr * a.rerr
  assign cmp_req.p0 = cmp_a.lerr;
  assign cmp_req.p1 = cmp_b.rerr;
  assign cmp_req.q0 = cmp_b.lerr;
  assign cmp_req.q1 = cmp_a.rerr;

  ccs_ratio_cmp u_cmp (
    .clk (clk),
    .req (cmp_req),
    .gt  (gt)
  );

  // memory port, compare operand steering and end of a sift
  always_comb begin
    we       = 1'b0;
    waddr    = pos_r;
    wdata    = x_r;
    raddr    = '0;
    cmp_a    = x_r;
    cmp_b    = rdata;
    done_nxt = 1'b0;
    unique case (st_r)
      H_IDLE: begin
        raddr = ccs_pkg::SLOT_W'(1);
        if (!req.clear) begin
          if (req.push) begin
            done_nxt = (fill_r >= ccs_pkg::HEAP_LIMIT);
          end else if (req.pop) begin
            done_nxt = (fill_r == '0);
          end
        end
      end
      H_UP: begin
        if (pos_r == ccs_pkg::SLOT_W'(1)) begin
          we       = 1'b1;
          done_nxt = 1'b1;
        end else begin
          raddr = pos_r >> 1;
        end
      end
      H_UP_RD: begin
        cmp_a = x_r;
        cmp_b = rdata;
      end
      H_UP_CMP: begin
        we       = 1'b1;
        wdata    = gt ? c_r : x_r;
        done_nxt = !gt;
      end
      H_POP_RD1: begin
        raddr = fill_r[ccs_pkg::SLOT_W-1:0];
      end
      H_POP_RD2: begin
        raddr = '0;
      end
      H_DN: begin
        if (cidx > fill_r) begin
          we       = 1'b1;
          done_nxt = 1'b1;
        end else begin
          raddr = cidx[ccs_pkg::SLOT_W-1:0];
        end
      end
      H_DN_RD1: begin
        raddr = c1idx[ccs_pkg::SLOT_W-1:0];
        cmp_a = rdata;
        cmp_b = x_r;
      end
      H_DN_RD2: begin
        cmp_a = c_r;
        cmp_b = rdata;
      end
      H_DN_CMPC: begin
        cmp_a = gt ? c_r : c1_r;
        cmp_b = x_r;
      end
      H_DN_CMPX: begin
        we       = 1'b1;
        wdata    = gt ? (sel_r ? c1_r : c_r) : x_r;
        done_nxt = !gt;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // sift sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= H_IDLE;
      fill_r   <= '0;
      done_r   <= 1'b0;
      popped_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      unique case (st_r)
        H_IDLE: begin
          if (req.clear) begin
            fill_r <= '0;
          end else if (req.push) begin
            if (fill_r < ccs_pkg::HEAP_LIMIT) begin
              fill_r <= fill_r + ccs_pkg::FILL_W'(1);
              pos_r  <= fill_r[ccs_pkg::SLOT_W-1:0] + ccs_pkg::SLOT_W'(1);
              x_r    <= req.entry;
              st_r   <= H_UP;
            end
          end else if (req.pop) begin
            if (fill_r == '0) begin
              popped_r <= 1'b0;
            end else begin
              st_r <= H_POP_RD1;
            end
          end
        end
        H_UP: begin
          if (pos_r == ccs_pkg::SLOT_W'(1)) begin
            st_r <= H_IDLE;
          end else begin
            st_r <= H_UP_RD;
          end
        end
        H_UP_RD: begin
          c_r  <= rdata;
          st_r <= H_UP_CMP;
        end
        H_UP_CMP: begin
          if (gt) begin
            pos_r <= pos_r >> 1;
            st_r  <= H_UP;
          end else begin
            st_r <= H_IDLE;
          end
        end
        H_POP_RD1: begin
          top_r <= rdata;
          st_r  <= H_POP_RD2;
        end
        H_POP_RD2: begin
          x_r      <= rdata;
          fill_r   <= fill_r - ccs_pkg::FILL_W'(1);
          pos_r    <= ccs_pkg::SLOT_W'(1);
          popped_r <= 1'b1;
          st_r     <= H_DN;
        end
        H_DN: begin
          if (cidx > fill_r) begin
            st_r <= H_IDLE;
          end else begin
            st_r <= H_DN_RD1;
          end
        end
        H_DN_RD1: begin
          c_r <= rdata;
          if (c1idx <= fill_r) begin
            st_r <= H_DN_RD2;
          end else begin
            sel_r <= 1'b0;
            st_r  <= H_DN_CMPX;
          end
        end
        H_DN_RD2: begin
          c1_r <= rdata;
          st_r <= H_DN_CMPC;
        end
        H_DN_CMPC: begin
          sel_r <= !gt;
          st_r  <= H_DN_CMPX;
        end
        H_DN_CMPX: begin
          if (gt) begin
            pos_r <= sel_r ? c1idx[ccs_pkg::SLOT_W-1:0] : cidx[ccs_pkg::SLOT_W-1:0];
            st_r  <= H_DN;
          end else begin
            st_r <= H_IDLE;
          end
        end
        default: begin
          st_r <= H_IDLE;
        end
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.popped = popped_r;
  assign rsp.top    = top_r;

endmodule

// ----- sv/cluster_count_search_sequencer_unit.sv -----
// channel   direction  handshake           payload
// in_       input      in_valid/in_stall   in_command, in_error_value
// out_      output     out_valid/out_stall out_status, out_next_count,
//                                          out_answer_slot, out_answer_count
// cfg_      input      cfg_wr_en           cfg_index, cfg_wdata
//
// one item at a time; a heap step is two sift-ups and one sift-down with two child
// reads a level, paced by the single read port of the heap memory and the
// registered compare.
// synchronous active-low reset, no clearing pass. in_stall is high while an
// item is worked on and while its result waits for the output register.
module cluster_count_search_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_error_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [9:0]  out_next_count,
  output logic [9:0]  out_answer_slot,
  output logic [9:0]  out_answer_count,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata
);

  typedef enum logic [3:0] {
    T_IDLE, T_BIS, T_BISC, T_PUSH0, T_WAIT0, T_PUSH1, T_WAIT1,
    T_POP, T_WAITP, T_ADV, T_FIN, T_EMIT
  } tstate_t;

  typedef enum logic [1:0] {
    PH_IDLE, PH_WAIT_MIN, PH_WAIT_MAX, PH_WAIT_MID
  } phase_t;

  localparam int SW = ccs_pkg::SLOT_W;
  localparam int FW = ccs_pkg::FILL_W;
  localparam int CW = ccs_pkg::CNT_W;
  localparam int EW = ccs_pkg::ERR_W;

  tstate_t          st_r;
  phase_t           phase_r;
  logic [CW-1:0]    min_r;
  logic [CW-1:0]    max_r;
  logic             mode_r;
  logic [FW-1:0]    fill_r;
  logic [SW-1:0]    lslot_r;
  logic [SW-1:0]    rslot_r;
  logic [CW-1:0]    lcnt_r;
  logic [CW-1:0]    rcnt_r;
  logic [EW-1:0]    lerr_r;
  logic [EW-1:0]    rerr_r;
  logic [CW-1:0]    last_r;
  logic [EW-1:0]    ierr_r;
  logic [SW-1:0]    m_r;
  logic [CW-1:0]    mc_r;
  logic [1:0]       res_stat_r;
  logic [CW-1:0]    res_next_r;
  logic [SW-1:0]    res_slot_r;
  logic [CW-1:0]    res_cnt_r;
  logic             out_valid_r;
  logic [1:0]       out_stat_r;
  logic [CW-1:0]    out_next_r;
  logic [SW-1:0]    out_slot_r;
  logic [CW-1:0]    out_cnt_r;

  logic             accept;
  logic [EW-1:0]    err_sat;
  logic [CW:0]      mid_sum;
  logic [CW-1:0]    mid;
  logic             more;
  logic [FW-1:0]    fill_m1;

  ccs_pkg::ccs_heap_req_t hreq;
  ccs_pkg::ccs_heap_rsp_t hrsp;
  ccs_pkg::ccs_cmp_req_t  breq;
  logic                   bgt;

  assign accept  = in_valid && !in_stall;
  assign err_sat = (in_error_value == '0) ? EW'(1) : in_error_value;
  assign mid_sum = {1'b0, lcnt_r} + {1'b0, rcnt_r};
  assign mid     = mid_sum[CW:1];
  assign more    = {1'b0, rcnt_r} > ({1'b0, lcnt_r} + (CW+1)'(1));
  assign fill_m1 = fill_r - FW'(1);

  // heap requests: clear on a start, split halves around the midpoint, then take the best
  always_comb begin
    hreq       = '0;
    hreq.clear = accept && (in_command == ccs_pkg::CMD_START);
    unique case (st_r)
      T_PUSH0: begin
        hreq.push        = 1'b1;
        hreq.entry.lslot = lslot_r;
        hreq.entry.rslot = m_r;
        hreq.entry.lcnt  = lcnt_r;
        hreq.entry.rcnt  = mc_r;
        hreq.entry.lerr  = lerr_r;
        hreq.entry.rerr  = ierr_r;
      end
      T_PUSH1: begin
        hreq.push        = 1'b1;
        hreq.entry.lslot = m_r;
        hreq.entry.rslot = rslot_r;
        hreq.entry.lcnt  = mc_r;
        hreq.entry.rcnt  = rcnt_r;
        hreq.entry.lerr  = ierr_r;
        hreq.entry.rerr  = rerr_r;
      end
      T_POP: begin
        hreq.pop = 1'b1;
      end
      default: begin
        hreq.push = 1'b0;
      end
    endcase
  end

  ccs_heap u_heap (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hreq),
    .rsp   (hrsp)
  );

  // bisection: keep the left half when lerr*rerr > err*err
  assign breq.p0 = lerr_r;
  assign breq.p1 = rerr_r;
  assign breq.q0 = ierr_r;
  assign breq.q1 = ierr_r;

  ccs_ratio_cmp u_bis_cmp (
    .clk (clk),
    .req (breq),
    .gt  (bgt)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= CW'(1);
      max_r  <= CW'(1023);
      mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ccs_pkg::CFG_MIN:  min_r  <= cfg_wdata;
        ccs_pkg::CFG_MAX:  max_r  <= cfg_wdata;
        ccs_pkg::CFG_MODE: mode_r <= cfg_wdata[0];
        default:           mode_r <= mode_r;
      endcase
    end
  end

  // search sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      phase_r     <= PH_IDLE;
      fill_r      <= '0;
      lslot_r     <= '0;
      rslot_r     <= SW'(1);
      out_valid_r <= 1'b0;
    end else begin
      // output valid: load on emit, drop after a transfer
      if (st_r == T_EMIT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        T_IDLE: begin
          if (accept) begin
            res_slot_r <= '0;
            res_cnt_r  <= '0;
            ierr_r     <= err_sat;
            if (in_command == ccs_pkg::CMD_START) begin
              fill_r     <= '0;
              lslot_r    <= '0;
              rslot_r    <= SW'(1);
              lcnt_r     <= min_r;
              rcnt_r     <= max_r;
              phase_r    <= PH_WAIT_MIN;
              res_stat_r <= ccs_pkg::STAT_NEXT;
              res_next_r <= min_r;
              st_r       <= T_EMIT;
            end else begin
              unique case (phase_r)
                PH_IDLE: begin
                  res_stat_r <= ccs_pkg::STAT_UNEXP;
                  res_next_r <= '0;
                  st_r       <= T_EMIT;
                end
                PH_WAIT_MIN: begin
                  lerr_r     <= err_sat;
                  fill_r     <= FW'(1);
                  phase_r    <= PH_WAIT_MAX;
                  res_stat_r <= ccs_pkg::STAT_NEXT;
                  res_next_r <= rcnt_r;
                  st_r       <= T_EMIT;
                end
                PH_WAIT_MAX: begin
                  rerr_r <= err_sat;
                  fill_r <= FW'(2);
                  last_r <= rcnt_r;
                  st_r   <= T_ADV;
                end
                PH_WAIT_MID: begin
                  if (fill_r[FW-1]) begin
                    st_r <= T_FIN;
                  end else begin
                    m_r    <= fill_r[SW-1:0];
                    mc_r   <= mid;
                    last_r <= mid;
                    fill_r <= fill_r + FW'(1);
                    st_r   <= mode_r ? T_BIS : T_PUSH0;
                  end
                end
                default: begin
                  res_stat_r <= ccs_pkg::STAT_UNEXP;
                  res_next_r <= '0;
                  st_r       <= T_EMIT;
                end
              endcase
            end
          end
        end
        T_BIS: begin
          st_r <= T_BISC;
        end
        T_BISC: begin
          if (bgt) begin
            rslot_r <= m_r;
            rcnt_r  <= mc_r;
            rerr_r  <= ierr_r;
          end else begin
            lslot_r <= m_r;
            lcnt_r  <= mc_r;
            lerr_r  <= ierr_r;
          end
          st_r <= T_ADV;
        end
        T_PUSH0: begin
          st_r <= T_WAIT0;
        end
        T_WAIT0: begin
          if (hrsp.done) begin
            st_r <= T_PUSH1;
          end
        end
        T_PUSH1: begin
          st_r <= T_WAIT1;
        end
        T_WAIT1: begin
          if (hrsp.done) begin
            st_r <= T_POP;
          end
        end
        T_POP: begin
          st_r <= T_WAITP;
        end
        T_WAITP: begin
          if (hrsp.done) begin
            if (hrsp.popped) begin
              lslot_r <= hrsp.top.lslot;
              rslot_r <= hrsp.top.rslot;
              lcnt_r  <= hrsp.top.lcnt;
              rcnt_r  <= hrsp.top.rcnt;
              lerr_r  <= hrsp.top.lerr;
              rerr_r  <= hrsp.top.rerr;
            end
            st_r <= T_ADV;
          end
        end
        T_ADV: begin
          if (more) begin
            phase_r    <= PH_WAIT_MID;
            res_stat_r <= ccs_pkg::STAT_NEXT;
            res_next_r <= mid;
            st_r       <= T_EMIT;
          end else begin
            st_r <= T_FIN;
          end
        end
        T_FIN: begin
          phase_r    <= PH_IDLE;
          res_stat_r <= ccs_pkg::STAT_DONE;
          res_next_r <= '0;
          res_slot_r <= mode_r ? fill_m1[SW-1:0] : rslot_r;
          res_cnt_r  <= mode_r ? last_r : rcnt_r;
          st_r       <= T_EMIT;
        end
        T_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_stat_r <= res_stat_r;
            out_next_r <= res_next_r;
            out_slot_r <= res_slot_r;
            out_cnt_r  <= res_cnt_r;
            st_r       <= T_IDLE;
          end
        end
        default: begin
          st_r <= T_IDLE;
        end
      endcase
    end
  end

  assign in_stall         = (st_r != T_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_stat_r;
  assign out_next_count   = out_next_r;
  assign out_answer_slot  = out_slot_r;
  assign out_answer_count = out_cnt_r;

endmodule
